[hw/rtl/tsc_pkg.sv]
// Package for the triangle scan converter: widths, fixed-point constants,
// controller state type and the command/status structs between controller and datapath.
// No dependencies.
package tsc_pkg;

    // Coordinate and store geometry.
    localparam int COORD_W   = 10;
    localparam int ROWS      = 1024;
    localparam int ROW_W     = $clog2(ROWS);
    localparam logic [COORD_W-1:0] X_MAX = COORD_W'((1 << COORD_W) - 1);

    // Edge stepping: unsigned 10.16 step, signed 12.16 position.
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = COORD_W + FRAC_W;
    localparam int POS_W     = QUO_W + 2;
    localparam int DIV_STEPS = QUO_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    // Request operation codes.
    localparam logic OP_TRIANGLE = 1'b0;
    localparam logic OP_READ     = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESP,
        ST_SETUP,
        ST_DIV,
        ST_WALK
    } t_state;

    typedef enum logic [1:0] {
        EDGE_LONG,
        EDGE_UPPER,
        EDGE_LOWER
    } t_edge;

    typedef struct packed {
        logic  load_item;
        logic  rd_en;
        t_edge edge_sel;
        logic  edge_setup;
        logic  div_step;
        logic  walk_step;
    } t_dp_cmd;

    typedef struct packed {
        logic edge_valid;
        logic div_last;
        logic walk_last;
    } t_dp_stat;

endpackage

[hw/rtl/tsc_if.sv]
// Handshake interfaces for the triangle scan converter request and span channels.
// Depends on tsc_pkg.
interface tsc_req_if;
    import tsc_pkg::*;

    logic               valid;
    logic               ready;
    logic               operation;
    logic [COORD_W-1:0] top_x;
    logic [COORD_W-1:0] top_y;
    logic [COORD_W-1:0] mid_x;
    logic [COORD_W-1:0] mid_y;
    logic [COORD_W-1:0] bottom_x;
    logic [COORD_W-1:0] bottom_y;
    logic               handedness;
    logic [COORD_W-1:0] row;

    modport source (
        output valid, operation, top_x, top_y, mid_x, mid_y, bottom_x, bottom_y,
               handedness, row,
        input  ready
    );
    modport sink (
        input  valid, operation, top_x, top_y, mid_x, mid_y, bottom_x, bottom_y,
               handedness, row,
        output ready
    );
endinterface

interface tsc_span_if;
    import tsc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] span_row;
    logic [COORD_W-1:0] span_start;
    logic [COORD_W-1:0] span_end;

    modport source (
        output valid, span_row, span_start, span_end,
        input  ready
    );
    modport sink (
        input  valid, span_row, span_start, span_end,
        output ready
    );
endinterface

[hw/rtl/tsc_ctrl.sv]
// Controller state machine of the triangle scan converter.
// Depends on tsc_pkg.
module tsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_op,
    output logic              o_req_ready,
    output logic              o_span_valid,
    input  logic              i_span_ready,
    output tsc_pkg::t_dp_cmd  o_cmd,
    input  tsc_pkg::t_dp_stat i_stat
);
    import tsc_pkg::*;

    t_state r_state, n_state;
    t_edge  r_edge,  n_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_edge  <= EDGE_LONG;
        end else begin
            r_state <= n_state;
            r_edge  <= n_edge;
        end
    end

    // Next state: setup per edge; a descending edge then divides and walks rows.
    always_comb begin
        n_state = r_state;
        n_edge  = r_edge;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    if (i_req_op == OP_READ) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_SETUP;
                        n_edge  = EDGE_LONG;
                    end
                end
            end
            ST_RESP: begin
                if (i_span_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SETUP: begin
                if (i_stat.edge_valid) begin
                    n_state = ST_DIV;
                end else if (r_edge == EDGE_LOWER) begin
                    n_state = ST_IDLE;
                end else begin
                    n_edge = t_edge'(r_edge + 2'd1);
                end
            end
            ST_DIV: begin
                if (i_stat.div_last) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_stat.walk_last) begin
                    if (r_edge == EDGE_LOWER) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_SETUP;
                        n_edge  = t_edge'(r_edge + 2'd1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req_ready      = 1'b0;
        o_span_valid     = 1'b0;
        o_cmd            = '0;
        o_cmd.edge_sel   = r_edge;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready     = 1'b1;
                o_cmd.load_item = i_req_valid && (i_req_op == OP_TRIANGLE);
                o_cmd.rd_en     = i_req_valid && (i_req_op == OP_READ);
            end
            ST_RESP:  o_span_valid     = 1'b1;
            ST_SETUP: o_cmd.edge_setup = 1'b1;
            ST_DIV:   o_cmd.div_step   = 1'b1;
            ST_WALK:  o_cmd.walk_step  = 1'b1;
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/tsc_dp.sv]
// Datapath of the triangle scan converter: vertex registers, bit-serial step divider,
// signed 12.16 edge walker and the two-sided scan store. Depends on tsc_pkg.
module tsc_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tsc_pkg::t_dp_cmd          i_cmd,
    output tsc_pkg::t_dp_stat         o_stat,
    input  logic [tsc_pkg::COORD_W-1:0] i_top_x,
    input  logic [tsc_pkg::COORD_W-1:0] i_top_y,
    input  logic [tsc_pkg::COORD_W-1:0] i_mid_x,
    input  logic [tsc_pkg::COORD_W-1:0] i_mid_y,
    input  logic [tsc_pkg::COORD_W-1:0] i_bottom_x,
    input  logic [tsc_pkg::COORD_W-1:0] i_bottom_y,
    input  logic                      i_handedness,
    input  logic [tsc_pkg::COORD_W-1:0] i_row,
    output logic [tsc_pkg::COORD_W-1:0] o_span_row,
    output logic [tsc_pkg::COORD_W-1:0] o_span_start,
    output logic [tsc_pkg::COORD_W-1:0] o_span_end
);
    import tsc_pkg::*;

    // Latched triangle.
    logic [COORD_W-1:0] r_tx, r_ty, r_mx, r_my, r_bx, r_by;
    logic               r_hand;

    // Edge selection.
    logic [COORD_W-1:0] x0, y0, x1, y1;
    logic               side;

    // Divider and walker.
    logic [QUO_W-1:0]   r_quo;
    logic [COORD_W-1:0] r_rem;
    logic [COORD_W-1:0] r_dy;
    logic [DCNT_W-1:0]  r_dcnt;
    logic               r_neg;
    logic               r_side;
    logic signed [POS_W-1:0] r_pos;
    logic [COORD_W-1:0] r_y, r_y_end;
    logic [COORD_W:0]   trial;
    logic               fits;
    logic [COORD_W-1:0] x_store;
    logic               y_in_range;

    // Scan store, one array per side.
    logic [COORD_W-1:0] mem_start [ROWS];
    logic [COORD_W-1:0] mem_end   [ROWS];
    logic [COORD_W-1:0] r_rd_start, r_rd_end, r_rd_row;
    logic               r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_tx   <= i_top_x;
            r_ty   <= i_top_y;
            r_mx   <= i_mid_x;
            r_my   <= i_mid_y;
            r_bx   <= i_bottom_x;
            r_by   <= i_bottom_y;
            r_hand <= i_handedness;
        end
    end

    always_comb begin
        case (i_cmd.edge_sel)
            EDGE_LONG: begin
                x0 = r_tx; y0 = r_ty; x1 = r_bx; y1 = r_by; side = r_hand;
            end
            EDGE_UPPER: begin
                x0 = r_tx; y0 = r_ty; x1 = r_mx; y1 = r_my; side = ~r_hand;
            end
            default: begin
                x0 = r_mx; y0 = r_my; x1 = r_bx; y1 = r_by; side = ~r_hand;
            end
        endcase
    end

    // Restoring division of |dx| << 16 by dy, one quotient bit per cycle.
    assign trial = {r_rem, r_quo[QUO_W-1]};
    assign fits  = trial >= {1'b0, r_dy};

    // Integer part of the position, clamped to the column range.
    always_comb begin
        if (r_pos[POS_W-1]) begin
            x_store = '0;
        end else if (|r_pos[POS_W-2:QUO_W]) begin
            x_store = X_MAX;
        end else begin
            x_store = r_pos[QUO_W-1:FRAC_W];
        end
    end

    assign y_in_range = {1'b0, r_y} < (COORD_W + 1)'(ROWS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.edge_setup) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_setup) begin
            r_neg   <= x1 < x0;
            r_quo   <= {((x1 < x0) ? (x0 - x1) : (x1 - x0)), FRAC_W'(0)};
            r_rem   <= '0;
            r_dy    <= y1 - y0;
            r_side  <= side;
            r_pos   <= POS_W'({x0, FRAC_W'(0)});
            r_y     <= y0;
            r_y_end <= y1;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[QUO_W-2:0], fits};
            r_rem <= fits ? COORD_W'(trial - {1'b0, r_dy}) : trial[COORD_W-1:0];
        end else if (i_cmd.walk_step) begin
            r_pos <= r_neg ? (r_pos - POS_W'(r_quo)) : (r_pos + POS_W'(r_quo));
            r_y   <= r_y + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_step && y_in_range) begin
            if (r_side) begin
                mem_end[r_y[ROW_W-1:0]] <= x_store;
            end else begin
                mem_start[r_y[ROW_W-1:0]] <= x_store;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_start <= mem_start[i_row[ROW_W-1:0]];
            r_rd_end   <= mem_end[i_row[ROW_W-1:0]];
            r_rd_row   <= i_row;
            r_rd_hit   <= {1'b0, i_row} < (COORD_W + 1)'(ROWS);
        end
    end

    assign o_span_row   = r_rd_row;
    assign o_span_start = r_rd_hit ? r_rd_start : '0;
    assign o_span_end   = r_rd_hit ? r_rd_end   : '0;

    assign o_stat.edge_valid = y1 > y0;
    assign o_stat.div_last   = r_dcnt == DCNT_W'(DIV_STEPS - 1);
    assign o_stat.walk_last  = (r_y + 1'b1) == r_y_end;

endmodule

[hw/rtl/triangle_scan_converter.sv]
// Top level of the triangle scan converter: controller plus datapath.
// Depends on tsc_pkg, tsc_if, tsc_ctrl and tsc_dp.
//
// Usage. Requests arrive on i_req (valid/ready). A request with operation 0 carries a
// triangle whose vertices are already sorted by y; the block walks the long edge into
// one side of the scan store and the two short edges into the other side, and returns
// nothing. A request with operation 1 reads one row and returns its span on o_span.
// Sequencing. The block works on one request at a time and drops
// i_req.ready while busy. A row read is accepted in idle and its span is shown
// on o_span in the cycle after, so no new read is taken before that span is delivered.
// A triangle runs, for each edge in turn, a setup step and, if the edge's end row lies
// below its start row, the bit-serial step divider and then a walk of one row per cycle.
// Reset. i_rst_n is synchronous and active low; it returns the controller to idle.
// The scan store is not cleared; a row must be written before it is read.
// Stalls. A span waits in its output register while o_span.ready is low, and no new
// request is taken until it has been delivered.
module triangle_scan_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsc_req_if.sink       i_req,
    tsc_span_if.source    o_span
);
    import tsc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     req_ready;
    logic     span_valid;

    tsc_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_op     (i_req.operation),
        .o_req_ready  (req_ready),
        .o_span_valid (span_valid),
        .i_span_ready (o_span.ready),
        .o_cmd        (cmd),
        .i_stat       (stat)
    );

    tsc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_top_x      (i_req.top_x),
        .i_top_y      (i_req.top_y),
        .i_mid_x      (i_req.mid_x),
        .i_mid_y      (i_req.mid_y),
        .i_bottom_x   (i_req.bottom_x),
        .i_bottom_y   (i_req.bottom_y),
        .i_handedness (i_req.handedness),
        .i_row        (i_req.row),
        .o_span_row   (o_span.span_row),
        .o_span_start (o_span.span_start),
        .o_span_end   (o_span.span_end)
    );

    // Handshake outputs come straight from the controller state.
    assign i_req.ready  = req_ready;
    assign o_span.valid = span_valid;

endmodule

[tb/triangle_scan_converter_tb.sv]
// Self-checking testbench for triangle_scan_converter: random triangles and row reads.
// Keeps its own scan store to predict every span and stalls both handshakes at random.
// Depends on tsc_pkg, tsc_if and the triangle_scan_converter RTL.
`timescale 1ns / 100ps

module triangle_scan_converter_tb;
    import tsc_pkg::*;

    // Run sizes. The drain covers the slowest request: setup plus three full-height edges.
    localparam int RANDOM_ITEMS = 1025;
    localparam int DRAIN_CYCLES = 3 + 3 * (DIV_STEPS + ROWS) + 64;
    localparam longint MAX_CYCLES = 10_000_000;
    localparam int MAX_PRINTED = 100;

    // One request as the testbench sees it; the fields mirror the request interface.
    typedef struct {
        logic               operation;
        logic [COORD_W-1:0] top_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] mid_x;
        logic [COORD_W-1:0] mid_y;
        logic [COORD_W-1:0] bottom_x;
        logic [COORD_W-1:0] bottom_y;
        logic               handedness;
        logic [COORD_W-1:0] row;
    } t_request;

    typedef struct {
        logic [COORD_W-1:0] span_row;
        logic [COORD_W-1:0] span_start;
        logic [COORD_W-1:0] span_end;
    } t_span;

    // The scoreboard owns a shadow of the scan store. Triangles update it as soon as the
    // request is accepted; a read request queues the span that the store holds right then.
    // The block takes one request at a time, so no read is taken before the RTL has caught up.
    class span_scoreboard;
        logic [COORD_W-1:0] row_start [ROWS];
        logic [COORD_W-1:0] row_end [ROWS];
        bit [1:0]           row_filled [ROWS];
        int                 readable_rows [$];
        t_span              pending_spans [$];
        int unsigned        errors;

        task report_mismatch(input string msg);
            if (errors < MAX_PRINTED)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Walks one edge row by row in signed 48.16 fixed point and stores the clamped floor of x.
        // An edge whose end row is not below its start row writes nothing.
        function void trace_edge(int x0, int y0, int x1, int y1, bit side);
            longint dy;
            longint dx;
            longint step;
            longint pos;
            longint xi;
            dy = longint'(y1) - longint'(y0);
            dx = longint'(x1) - longint'(x0);
            if (dy <= 0)
                return;
            step = (dx * (longint'(1) << FRAC_W)) / dy;
            pos = longint'(x0) << FRAC_W;
            for (int y = y0; y < y1; y++) begin
                if (y < ROWS) begin
                    xi = (pos < 0) ? 0 : (pos >>> FRAC_W);
                    if (xi > longint'(X_MAX))
                        xi = longint'(X_MAX);
                    if (side)
                        row_end[y] = xi[COORD_W-1:0];
                    else
                        row_start[y] = xi[COORD_W-1:0];
                    // A row becomes readable once both of its entries have been written.
                    if (row_filled[y] != 2'b11) begin
                        row_filled[y][side] = 1'b1;
                        if (row_filled[y] == 2'b11)
                            readable_rows.push_back(y);
                    end
                end
                pos += step;
            end
        endfunction

        function bit is_readable(int y);
            return (y >= 0) && (y < ROWS) && (row_filled[y] == 2'b11);
        endfunction

        function int pending();
            return pending_spans.size();
        endfunction

        // Called for every accepted request.
        function void note_request(t_request r);
            t_span s;
            if (r.operation == OP_TRIANGLE) begin
                // Long edge first, then the two short edges on the opposite side.
                trace_edge(int'(r.top_x), int'(r.top_y), int'(r.bottom_x), int'(r.bottom_y),
                           r.handedness);
                trace_edge(int'(r.top_x), int'(r.top_y), int'(r.mid_x), int'(r.mid_y),
                           !r.handedness);
                trace_edge(int'(r.mid_x), int'(r.mid_y), int'(r.bottom_x), int'(r.bottom_y),
                           !r.handedness);
            end else begin
                s.span_row = r.row;
                if (int'(r.row) < ROWS) begin
                    s.span_start = row_start[r.row];
                    s.span_end = row_end[r.row];
                end else begin
                    s.span_start = '0;
                    s.span_end = '0;
                end
                pending_spans.push_back(s);
            end
        endfunction

        // Called for every accepted span; compares it against the oldest expectation.
        task check_span(input t_span got);
            t_span want;
            if (pending_spans.size() == 0) begin
                report_mismatch($sformatf("unexpected span row=%0d start=%0d end=%0d",
                                          got.span_row, got.span_start, got.span_end));
                return;
            end
            want = pending_spans.pop_front();
            if (got.span_row !== want.span_row)
                report_mismatch($sformatf("span_row got %0d, expected %0d",
                                          got.span_row, want.span_row));
            if (got.span_start !== want.span_start)
                report_mismatch($sformatf("row %0d span_start got %0d, expected %0d",
                                          want.span_row, got.span_start, want.span_start));
            if (got.span_end !== want.span_end)
                report_mismatch($sformatf("row %0d span_end got %0d, expected %0d",
                                          want.span_row, got.span_end, want.span_end));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    tsc_req_if  req_bus ();
    tsc_span_if span_bus ();

    triangle_scan_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus.sink),
        .o_span  (span_bus.source)
    );

    span_scoreboard board;
    longint         cycle_count;
    bit             calm;          // when set, neither side inserts idle cycles
    int             stall_left;
    int             last_lo;       // rows touched by the most recent triangle
    int             last_hi;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs or stops handing out spans.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("triangle_scan_converter_tb: FAIL");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one, none at all in calm stretches.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Span side: check whatever was accepted at this edge, then decide ready for the next.
    always @(posedge i_clk) begin
        t_span got;
        if (!i_rst_n) begin
            span_bus.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (span_bus.valid === 1'b1 && span_bus.ready === 1'b1) begin
                got.span_row = span_bus.span_row;
                got.span_start = span_bus.span_start;
                got.span_end = span_bus.span_end;
                board.check_span(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                span_bus.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < 20) begin
                stall_left = pick_stall() - 1;
                span_bus.ready <= 1'b0;
            end else begin
                span_bus.ready <= 1'b1;
            end
        end
    end

    // Presents one request and returns at the edge where it was accepted. Called right
    // after an edge, so valid changes at most once per time step.
    task automatic drive_request(input t_request r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.operation  <= r.operation;
        req_bus.top_x      <= r.top_x;
        req_bus.top_y      <= r.top_y;
        req_bus.mid_x      <= r.mid_x;
        req_bus.mid_y      <= r.mid_y;
        req_bus.bottom_x   <= r.bottom_x;
        req_bus.bottom_y   <= r.bottom_y;
        req_bus.handedness <= r.handedness;
        req_bus.row        <= r.row;
        do
            @(posedge i_clk);
        while (!(req_bus.valid === 1'b1 && req_bus.ready === 1'b1));
        board.note_request(r);
    endtask

    // Fields that the operation ignores still carry random values.
    task automatic send_triangle(input int tx, input int ty, input int mx, input int my,
                                 input int bx, input int by, input bit hand);
        t_request r;
        r.operation = OP_TRIANGLE;
        r.top_x = COORD_W'(tx);
        r.top_y = COORD_W'(ty);
        r.mid_x = COORD_W'(mx);
        r.mid_y = COORD_W'(my);
        r.bottom_x = COORD_W'(bx);
        r.bottom_y = COORD_W'(by);
        r.handedness = hand;
        r.row = COORD_W'($urandom_range(0, ROWS - 1));
        drive_request(r);
    endtask

    task automatic send_read(input int y);
        t_request r;
        r.operation = OP_READ;
        r.top_x = COORD_W'($urandom_range(0, 1023));
        r.top_y = COORD_W'($urandom_range(0, 1023));
        r.mid_x = COORD_W'($urandom_range(0, 1023));
        r.mid_y = COORD_W'($urandom_range(0, 1023));
        r.bottom_x = COORD_W'($urandom_range(0, 1023));
        r.bottom_y = COORD_W'($urandom_range(0, 1023));
        r.handedness = 1'($urandom_range(0, 1));
        r.row = COORD_W'(y);
        drive_request(r);
    endtask

    function int rand_x();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 0;
        if (r == 1)
            return int'(X_MAX);
        return $urandom_range(0, int'(X_MAX));
    endfunction

    // Mostly short, well-ordered triangles so the store sees many distinct writes; a few
    // tall ones, and some with vertices out of order whose edges are partly skipped.
    task automatic random_triangle();
        int kind;
        int height;
        int base;
        int ya;
        int yb;
        int yc;
        int t;
        kind = $urandom_range(0, 99);
        if (kind < 85) begin
            height = $urandom_range(0, 48);
            ya = $urandom_range(0, ROWS - 1 - height);
            yc = ya + height;
            yb = $urandom_range(ya, yc);
        end else begin
            if (kind < 92) begin
                ya = $urandom_range(0, ROWS - 1);
                yb = $urandom_range(0, ROWS - 1);
                yc = $urandom_range(0, ROWS - 1);
            end else begin
                base = $urandom_range(0, ROWS - 65);
                ya = base + $urandom_range(0, 64);
                yb = base + $urandom_range(0, 64);
                yc = base + $urandom_range(0, 64);
            end
            // Tall triangles get sorted; the out-of-order ones stay as drawn.
            if (kind < 92) begin
                if (ya > yb) begin t = ya; ya = yb; yb = t; end
                if (yb > yc) begin t = yb; yb = yc; yc = t; end
                if (ya > yb) begin t = ya; ya = yb; yb = t; end
            end
        end
        last_lo = (ya < yb) ? ((ya < yc) ? ya : yc) : ((yb < yc) ? yb : yc);
        last_hi = (ya > yb) ? ((ya > yc) ? ya : yc) : ((yb > yc) ? yb : yc);
        send_triangle(rand_x(), ya, rand_x(), yb, rand_x(), yc, 1'($urandom_range(0, 1)));
    endtask

    // Reads favor the rows of the latest triangle; otherwise any row written so far.
    task automatic random_read();
        int y;
        y = -1;
        if ($urandom_range(0, 1) == 1 && last_hi > last_lo) begin
            y = $urandom_range(last_lo, last_hi - 1);
            if (!board.is_readable(y))
                y = -1;
        end
        if (y < 0)
            y = board.readable_rows[$urandom_range(0, board.readable_rows.size() - 1)];
        send_read(y);
    endtask

    initial begin
        board = new;
        cycle_count = 0;
        calm = 1'b0;
        stall_left = 0;
        last_lo = 0;
        last_hi = 0;
        i_rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.operation = OP_TRIANGLE;
        req_bus.top_x = '0;
        req_bus.top_y = '0;
        req_bus.mid_x = '0;
        req_bus.mid_y = '0;
        req_bus.bottom_x = '0;
        req_bus.bottom_y = '0;
        req_bus.handedness = 1'b0;
        req_bus.row = '0;
        span_bus.ready = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full-height triangle first, so that every row up to the last reachable one holds
        // a defined span before anything is read. The bottom row is exclusive, so row
        // ROWS-1 can never be written and is never read.
        send_triangle(0, 0, int'(X_MAX), 512, 0, ROWS - 1, 1'b0);
        send_read(0);
        send_read(511);
        send_read(512);
        send_read(ROWS - 2);

        // Mirror image with the long edge on the span end and steep short edges.
        send_triangle(int'(X_MAX), 10, 0, 300, int'(X_MAX), 700, 1'b1);
        send_read(10);
        send_read(299);
        send_read(300);
        send_read(699);

        // Flat top: the upper short edge has no rows.
        send_triangle(100, 800, 900, 800, 500, 900, 1'b0);
        send_read(800);
        send_read(899);

        // Flat bottom: the lower short edge has no rows.
        send_triangle(500, 900, 100, 950, 900, 950, 1'b1);
        send_read(900);
        send_read(949);

        // All three vertices on one row: nothing is written and row 20 keeps its span.
        send_triangle(5, 20, 600, 20, int'(X_MAX), 20, 1'b0);
        send_read(20);

        // Vertices out of order: only the edges that still descend write.
        send_triangle(0, 1000, int'(X_MAX), 500, int'(X_MAX), 100, 1'b1);
        send_triangle(200, 100, 800, 400, 300, 200, 1'b0);
        send_read(150);
        send_read(350);

        // One-row edges with the largest negative step.
        send_triangle(int'(X_MAX), 0, 0, 1, 0, 1, 1'b1);
        send_read(0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 35 || board.readable_rows.size() == 0)
                random_triangle();
            else
                random_read();
        end
        req_bus.valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0)
            $display("triangle_scan_converter_tb: PASS");
        else
            $display("triangle_scan_converter_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_if.sv
hw/rtl/tsc_ctrl.sv
hw/rtl/tsc_dp.sv
hw/rtl/triangle_scan_converter.sv
tb/triangle_scan_converter_tb.sv
